@@ hw/rtl/aqf_pkg.sv @@
// aqf_pkg: shared types, constants and register codes for the alarm qualifier
`timescale 1ns / 1ps
`default_nettype none

package aqf_pkg;

    // build options
    localparam int CHANNELS   = 4;
    localparam int DELAY_BITS = 16;

    // fixed field widths
    localparam int CH_BITS       = 2;
    localparam int COND_BITS     = 2;
    localparam int EV_BITS       = 2;
    localparam int MAP_BITS      = 4;
    localparam int MODE_BITS     = 12;
    localparam int MODE_CH_BITS  = 3;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    // channel index width into per-channel storage
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // condition codes
    localparam logic [COND_BITS-1:0] CND_CLEARED   = 2'd0;
    localparam logic [COND_BITS-1:0] CND_TRIGGERED = 2'd1;

    // per-channel mode bits
    localparam logic [1:0] MODE_EN_MASK = 2'h3;
    localparam logic [1:0] MODE_DISABLE = 2'h2;
    localparam int         MODE_AUTO_BIT = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_MODES  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_DELAY0 = 3'd1;

    typedef enum logic [1:0] {
        PH_INACTIVE = 2'd0,
        PH_PRE      = 2'd1,
        PH_ACTIVE   = 2'd2,
        PH_POST     = 2'd3
    } t_phase;

    typedef enum logic [EV_BITS-1:0] {
        EV_NONE   = 2'd0,
        EV_RAISED = 2'd1,
        EV_ENDED  = 2'd2
    } t_event;

    // configuration seen by one channel
    typedef struct packed {
        logic                  dis;
        logic                  autorel;
        logic [DELAY_BITS-1:0] dly;
    } t_chan_cfg;

    // outcome of one scan step
    typedef struct packed {
        t_phase                phase;
        logic [DELAY_BITS-1:0] count;
        t_event                ev;
    } t_step;

endpackage

`default_nettype wire

@@ hw/rtl/aqf_ifs.sv @@
// aqf_ifs: valid/ready channel interfaces for scan steps, results and config writes
`timescale 1ns / 1ps
`default_nettype none

interface aqf_in_if import aqf_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CH_BITS-1:0]   channel;
    logic [COND_BITS-1:0] condition;

    modport source (output valid, output channel, output condition, input ready);
    modport sink   (input valid, input channel, input condition, output ready);
endinterface

interface aqf_out_if import aqf_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [EV_BITS-1:0]  event_res;
    logic [CH_BITS-1:0]  event_channel;
    logic [1:0]          channel_state;
    logic [MAP_BITS-1:0] active_bitmap;

    modport source (output valid, output event_res, output event_channel,
                    output channel_state, output active_bitmap, input ready);
    modport sink   (input valid, input event_res, input event_channel,
                    input channel_state, input active_bitmap, output ready);
endinterface

interface aqf_cfg_if import aqf_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/alarm_qualify_fsm.sv @@
// alarm_qualify_fsm: four-channel alarm qualifier top level
// path: input register, then result register; an accepted input beat moves
// on into the result register once the output side is free
// throughput: one input beat per cycle while the result side is not stalled
// a step that follows on the same channel sees the state its predecessor left
// reset (synchronous, active low) clears all phases, countdowns, the alarm
// bitmap, the mode and delay registers and both pipeline valid flags
`timescale 1ns / 1ps
`default_nettype none

module alarm_qualify_fsm import aqf_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    aqf_in_if.sink    i_in,
    aqf_cfg_if.sink   i_cfg,
    aqf_out_if.source o_out
);

    // input register
    logic                  r_in_valid;
    logic [CH_BITS-1:0]    r_in_ch;
    logic [COND_BITS-1:0]  r_in_cnd;

    // channel state
    t_phase                r_phase [CHANNELS];
    logic [DELAY_BITS-1:0] r_count [CHANNELS];
    logic [MAP_BITS-1:0]   r_raised;
    logic [MAP_BITS-1:0]   n_raised;

    // result register
    logic                  r_out_valid;
    t_event                r_out_ev;
    logic [CH_BITS-1:0]    r_out_ch;
    t_phase                r_out_state;
    logic [MAP_BITS-1:0]   r_out_map;

    logic                  out_free;
    logic                  adv;
    logic                  ch_ok;
    logic [CH_IDX_W-1:0]   idx;
    logic [MAP_BITS-1:0]   ch_bit;
    t_chan_cfg             chan_cfg;
    t_step                 step;
    t_phase                n_state;
    t_event                n_ev;

    // handshake
    assign out_free   = !r_out_valid || o_out.ready;
    assign adv        = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || out_free;

    assign ch_ok  = ({1'b0, r_in_ch} < (CH_BITS + 1)'(CHANNELS));
    assign idx    = r_in_ch[CH_IDX_W-1:0];
    assign ch_bit = MAP_BITS'(1) << r_in_ch;

    aqf_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (i_cfg),
        .i_sel      (idx),
        .o_chan_cfg (chan_cfg)
    );

    aqf_chan_step u_step (
        .i_phase (r_phase[idx]),
        .i_count (r_count[idx]),
        .i_cond  (r_in_cnd),
        .i_cfg   (chan_cfg),
        .o_step  (step)
    );

    // bitmap and result fields for the step in flight
    always_comb begin
        n_raised = r_raised;
        n_state  = PH_INACTIVE;
        n_ev     = EV_NONE;
        if (ch_ok) begin
            n_state = step.phase;
            n_ev    = step.ev;
            if (step.ev == EV_RAISED) begin
                n_raised = r_raised | ch_bit;
            end else if (step.ev == EV_ENDED) begin
                n_raised = r_raised & ~ch_bit;
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_ch  <= i_in.channel;
            r_in_cnd <= i_in.condition;
        end
    end

    // channel state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raised <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_phase[c] <= PH_INACTIVE;
                r_count[c] <= '0;
            end
        end else if (adv && ch_ok) begin
            r_raised     <= n_raised;
            r_phase[idx] <= step.phase;
            r_count[idx] <= step.count;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_ev    <= n_ev;
            r_out_ch    <= r_in_ch;
            r_out_state <= n_state;
            r_out_map   <= n_raised;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.event_res     = r_out_ev;
    assign o_out.event_channel = r_out_ch;
    assign o_out.channel_state = r_out_state;
    assign o_out.active_bitmap = r_out_map;

endmodule

`default_nettype wire

@@ hw/rtl/aqf_cfg_regs.sv @@
// aqf_cfg_regs: mode and delay registers with per-channel selection
`timescale 1ns / 1ps
`default_nettype none

module aqf_cfg_regs import aqf_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    aqf_cfg_if.sink                  i_cfg,
    input  wire logic [CH_IDX_W-1:0] i_sel,
    output t_chan_cfg                o_chan_cfg
);

    logic [MODE_BITS-1:0]    r_modes;
    logic [DELAY_BITS-1:0]   r_delay [CHANNELS];
    logic [MODE_CH_BITS-1:0] chan_mode [CHANNELS];
    logic                    wr;

    // writes are always taken
    assign i_cfg.ready = 1'b1;
    assign wr = i_cfg.valid;

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modes <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_delay[c] <= '0;
            end
        end else if (wr) begin
            if (i_cfg.index == REG_MODES) begin
                r_modes <= i_cfg.data[MODE_BITS-1:0];
            end
            for (int c = 0; c < CHANNELS; c++) begin
                if (i_cfg.index == CFG_IDX_BITS'(REG_DELAY0 + c)) begin
                    r_delay[c] <= i_cfg.data[DELAY_BITS-1:0];
                end
            end
        end
    end

    // split modes into per-channel fields
    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            chan_mode[c] = r_modes[MODE_CH_BITS*c +: MODE_CH_BITS];
        end
    end

    // selected channel view
    always_comb begin
        o_chan_cfg.dis     = (chan_mode[i_sel][1:0] & MODE_EN_MASK) == MODE_DISABLE;
        o_chan_cfg.autorel = chan_mode[i_sel][MODE_AUTO_BIT];
        o_chan_cfg.dly     = r_delay[i_sel];
    end

endmodule

`default_nettype wire

@@ hw/rtl/aqf_chan_step.sv @@
// aqf_chan_step: next phase, countdown and event for one channel scan step
`timescale 1ns / 1ps
`default_nettype none

module aqf_chan_step import aqf_pkg::*; (
    input  wire t_phase                i_phase,
    input  wire logic [DELAY_BITS-1:0] i_count,
    input  wire logic [COND_BITS-1:0]  i_cond,
    input  wire t_chan_cfg             i_cfg,
    output t_step                      o_step
);

    logic trig;
    logic clr;
    logic cnt_nz;

    assign trig   = (i_cond == CND_TRIGGERED);
    assign clr    = (i_cond == CND_CLEARED);
    assign cnt_nz = (i_count != '0);

    // phase transitions; hold and unused codes keep the state unless the channel is disabled
    always_comb begin
        o_step.phase = i_phase;
        o_step.count = i_count;
        o_step.ev    = EV_NONE;
        if (!(i_cfg.dis && i_phase == PH_INACTIVE)) begin
            unique case (i_phase)
                PH_INACTIVE: begin
                    if (trig) begin
                        o_step.count = i_cfg.dly;
                        o_step.phase = PH_PRE;
                    end
                end
                PH_PRE: begin
                    if (i_cfg.dis) begin
                        o_step.phase = PH_INACTIVE;
                    end else if (trig) begin
                        if (cnt_nz) begin
                            o_step.count = i_count - 1'b1;
                        end else begin
                            o_step.phase = PH_ACTIVE;
                            o_step.ev    = EV_RAISED;
                        end
                    end else if (clr) begin
                        o_step.count = '0;
                        o_step.phase = PH_INACTIVE;
                    end
                end
                PH_ACTIVE: begin
                    if (i_cfg.dis) begin
                        o_step.count = '0;
                        o_step.phase = PH_POST;
                    end else if (trig) begin
                        o_step.count = '0;
                    end else if (clr && i_cfg.autorel) begin
                        o_step.count = i_cfg.dly;
                        o_step.phase = PH_POST;
                    end
                end
                PH_POST: begin
                    if (i_cfg.dis) begin
                        o_step.count = '0;
                        o_step.phase = PH_INACTIVE;
                        o_step.ev    = EV_ENDED;
                    end else if (clr) begin
                        if (cnt_nz) begin
                            o_step.count = i_count - 1'b1;
                        end else begin
                            o_step.phase = PH_INACTIVE;
                            o_step.ev    = EV_ENDED;
                        end
                    end else if (trig) begin
                        o_step.count = '0;
                        o_step.phase = PH_ACTIVE;
                    end
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/aqf_checker.sv @@
// aqf_checker: port-level assertions for the alarm qualifier and its bind
`timescale 1ns / 1ps
`default_nettype none

module aqf_checker import aqf_pkg::*; (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_out_valid,
    input wire logic                i_out_ready,
    input wire logic [EV_BITS-1:0]  i_event_res,
    input wire logic [CH_BITS-1:0]  i_event_channel,
    input wire logic [1:0]          i_channel_state,
    input wire logic [MAP_BITS-1:0] i_active_bitmap
);

    // a stalled result beat keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid
            && $stable(i_event_res) && $stable(i_channel_state)
            && $stable(i_event_channel) && $stable(i_active_bitmap))
        else $error("result beat changed while stalled");

    // nothing is presented right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result valid right after reset");

    // a raised alarm shows as active with its bit set
    a_raised: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_event_res == EV_RAISED |->
            i_channel_state == PH_ACTIVE && i_active_bitmap[i_event_channel])
        else $error("raised event without active state or bitmap bit");

    // an ended alarm shows as inactive with its bit clear
    a_ended: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_event_res == EV_ENDED |->
            i_channel_state == PH_INACTIVE && !i_active_bitmap[i_event_channel])
        else $error("ended event without inactive state or cleared bit");

endmodule

bind alarm_qualify_fsm aqf_checker u_aqf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_event_res     (o_out.event_res),
    .i_event_channel (o_out.event_channel),
    .i_channel_state (o_out.channel_state),
    .i_active_bitmap (o_out.active_bitmap)
);

`default_nettype wire

@@ tb/alarm_qualify_fsm_tb.sv @@
// alarm_qualify_fsm_tb: self-checking testbench for the four-channel alarm qualifier
`timescale 1ns / 1ps

module alarm_qualify_fsm_tb;
    import aqf_pkg::*;

    // condition codes the package leaves unnamed
    localparam logic [COND_BITS-1:0] COND_HOLD = 2'd2;
    localparam logic [COND_BITS-1:0] COND_RSVD = 2'd3;

    // first and last register index that maps to nothing
    localparam int REG_SPARE_LO = REG_DELAY0 + CHANNELS;
    localparam int REG_SPARE_HI = (1 << CFG_IDX_BITS) - 1;

    localparam int SETTLE_CYCLES   = 4;
    localparam int CYCLE_LIMIT     = 500000;
    localparam int RAND_PHASES     = 14;
    localparam int STEPS_PER_PHASE = 122;
    localparam int MAX_ERR_LINES   = 40;

    typedef enum logic [1:0] {
        JOB_STEP,
        JOB_CFG,
        JOB_DRAIN
    } t_job_kind;

    // one entry of the stimulus list: a scan step, a register write or a drain
    typedef struct {
        t_job_kind               kind;
        logic [CFG_IDX_BITS-1:0] idx;
        logic [CFG_DATA_BITS-1:0] data;
        logic [CH_BITS-1:0]      ch;
        logic [COND_BITS-1:0]    cond;
        bit                      calm;
    } t_scan_job;

    // one predicted result beat
    typedef struct packed {
        t_event              ev;
        logic [CH_BITS-1:0]  ch;
        t_phase              st;
        logic [MAP_BITS-1:0] map;
    } t_alarm_res;

    logic i_clk;
    logic i_rst_n;

    aqf_in_if  in_bus ();
    aqf_cfg_if cfg_bus ();
    aqf_out_if out_bus ();

    alarm_qualify_fsm uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .i_cfg   (cfg_bus),
        .o_out   (out_bus)
    );

    // predictor state and registers
    t_phase                 ch_phase [CHANNELS];
    logic [DELAY_BITS-1:0]  ch_count [CHANNELS];
    logic [MAP_BITS-1:0]    raised_map;
    logic [MODE_BITS-1:0]   mode_bits;
    logic [CFG_DATA_BITS-1:0] ch_delay [CHANNELS];

    t_scan_job  scan_jobs [$];
    t_alarm_res pending_results [$];

    bit calm_now;
    bit calm;
    bit drain_wait;
    int settle_left;
    int idle_left;
    int stall_left;
    int cycles;
    int errors;
    int steps_taken;
    int results_seen;
    int raised_seen;
    int ended_seen;
    int reg_writes;

    // clock
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic flag_error(input string msg);
        if (errors < MAX_ERR_LINES)
            $display("ERROR @%0t: %s", $time, msg);
        errors++;
    endtask

    task automatic push_job(input t_job_kind kind, input int a, input int b);
        t_scan_job j;
        j.kind = kind;
        j.ch   = a[CH_BITS-1:0];
        j.cond = b[COND_BITS-1:0];
        j.idx  = a[CFG_IDX_BITS-1:0];
        j.data = b[CFG_DATA_BITS-1:0];
        j.calm = calm_now;
        scan_jobs.push_back(j);
    endtask

    // register write as the block applies it
    task automatic apply_reg_write(input logic [CFG_IDX_BITS-1:0] idx,
                                   input logic [CFG_DATA_BITS-1:0] data);
        if (idx == REG_MODES)
            mode_bits = data[MODE_BITS-1:0];
        else if (idx >= REG_DELAY0 && idx < REG_DELAY0 + CHANNELS)
            ch_delay[idx - REG_DELAY0] = data;
    endtask

    // one scan step of the qualifier: updates the channel and returns its result
    function automatic t_alarm_res qualify_step(input logic [CH_BITS-1:0] ch,
                                                input logic [COND_BITS-1:0] cnd);
        logic [MODE_CH_BITS-1:0] mode;
        logic                    dis;
        logic                    autorel;
        logic [DELAY_BITS-1:0]   dly;
        t_alarm_res              r;

        r.ev = EV_NONE;
        r.ch = ch;
        r.st = PH_INACTIVE;
        r.map = raised_map;
        if (ch >= CHANNELS)
            return r;

        mode    = mode_bits[MODE_CH_BITS*ch +: MODE_CH_BITS];
        dis     = (mode[1:0] & MODE_EN_MASK) == MODE_DISABLE;
        autorel = mode[MODE_AUTO_BIT];
        dly     = ch_delay[ch][DELAY_BITS-1:0];

        case (ch_phase[ch])
            PH_INACTIVE: begin
                // a disabled idle channel is skipped
                if (!dis && cnd == CND_TRIGGERED) begin
                    ch_count[ch] = dly;
                    ch_phase[ch] = PH_PRE;
                end
            end
            PH_PRE: begin
                if (dis) begin
                    ch_phase[ch] = PH_INACTIVE;
                end else if (cnd == CND_TRIGGERED) begin
                    if (ch_count[ch] != '0) begin
                        ch_count[ch] = ch_count[ch] - 1'b1;
                    end else begin
                        ch_phase[ch] = PH_ACTIVE;
                        raised_map[ch] = 1'b1;
                        r.ev = EV_RAISED;
                    end
                end else if (cnd == CND_CLEARED) begin
                    ch_count[ch] = '0;
                    ch_phase[ch] = PH_INACTIVE;
                end
            end
            PH_ACTIVE: begin
                if (dis) begin
                    ch_count[ch] = '0;
                    ch_phase[ch] = PH_POST;
                end else if (cnd == CND_TRIGGERED) begin
                    ch_count[ch] = '0;
                end else if (cnd == CND_CLEARED && autorel) begin
                    ch_count[ch] = dly;
                    ch_phase[ch] = PH_POST;
                end
            end
            default: begin
                if (dis) begin
                    raised_map[ch] = 1'b0;
                    ch_phase[ch] = PH_INACTIVE;
                    ch_count[ch] = '0;
                    r.ev = EV_ENDED;
                end else if (cnd == CND_CLEARED) begin
                    if (ch_count[ch] != '0) begin
                        ch_count[ch] = ch_count[ch] - 1'b1;
                    end else begin
                        raised_map[ch] = 1'b0;
                        ch_phase[ch] = PH_INACTIVE;
                        r.ev = EV_ENDED;
                    end
                end else if (cnd == CND_TRIGGERED) begin
                    ch_count[ch] = '0;
                    ch_phase[ch] = PH_ACTIVE;
                end
            end
        endcase

        r.st = ch_phase[ch];
        r.map = raised_map;
        return r;
    endfunction

    // weighted condition: mostly triggered and cleared so channels move on
    function automatic logic [COND_BITS-1:0] pick_cond();
        int r;
        r = $urandom_range(0, 19);
        if (r < 8)
            return CND_TRIGGERED;
        else if (r < 15)
            return CND_CLEARED;
        else if (r < 18)
            return COND_HOLD;
        return COND_RSVD;
    endfunction

    // random mode field for one channel, disabled about one time in five
    function automatic logic [MODE_CH_BITS-1:0] pick_mode();
        logic [1:0] en;
        en = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 9) < 2)
            en = MODE_DISABLE;
        else if (en == MODE_DISABLE)
            en = MODE_EN_MASK;
        return {1'($urandom_range(0, 1)), en};
    endfunction

    // input and config driver
    always @(posedge i_clk) begin
        logic in_v;
        logic cfg_v;
        t_scan_job j;

        if (!i_rst_n) begin
            in_bus.valid  <= 1'b0;
            cfg_bus.valid <= 1'b0;
        end else begin
            in_v  = in_bus.valid;
            cfg_v = cfg_bus.valid;
            // hold a beat that has not been taken yet
            if (!((in_bus.valid && !in_bus.ready) || (cfg_bus.valid && !cfg_bus.ready))) begin
                in_v  = 1'b0;
                cfg_v = 1'b0;
                if (idle_left > 0) begin
                    idle_left--;
                end else if (drain_wait) begin
                    if (pending_results.size() != 0 || in_bus.valid)
                        settle_left = SETTLE_CYCLES;
                    else if (settle_left > 0)
                        settle_left--;
                    else
                        drain_wait = 1'b0;
                end else if (scan_jobs.size() != 0) begin
                    j = scan_jobs.pop_front();
                    calm = j.calm;
                    case (j.kind)
                        JOB_DRAIN: begin
                            drain_wait  = 1'b1;
                            settle_left = SETTLE_CYCLES;
                        end
                        JOB_CFG: begin
                            cfg_v = 1'b1;
                            cfg_bus.index <= j.idx;
                            cfg_bus.data  <= j.data;
                        end
                        default: begin
                            in_v = 1'b1;
                            in_bus.channel   <= j.ch;
                            in_bus.condition <= j.cond;
                            if (!j.calm && $urandom_range(0, 5) == 0)
                                idle_left = $urandom_range(1, 18);
                        end
                    endcase
                end
            end
            in_bus.valid  <= in_v;
            cfg_bus.valid <= cfg_v;
        end
    end

    // monitor: predict on accepted beats, check results, stall the output side
    always @(posedge i_clk) begin
        t_alarm_res want;
        logic rdy;

        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
        end else begin
            if (cfg_bus.valid && cfg_bus.ready) begin
                apply_reg_write(cfg_bus.index, cfg_bus.data);
                reg_writes++;
            end
            if (in_bus.valid && in_bus.ready) begin
                pending_results.push_back(qualify_step(in_bus.channel, in_bus.condition));
                steps_taken++;
            end
            if (out_bus.valid && out_bus.ready) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    flag_error("result beat with nothing expected");
                end else begin
                    want = pending_results.pop_front();
                    if (want.ev == EV_RAISED)
                        raised_seen++;
                    if (want.ev == EV_ENDED)
                        ended_seen++;
                    if (out_bus.event_res !== want.ev)
                        flag_error($sformatf("event_res got %0d want %0d (ch %0d)",
                                             out_bus.event_res, want.ev, want.ch));
                    if (out_bus.event_channel !== want.ch)
                        flag_error($sformatf("event_channel got %0d want %0d",
                                             out_bus.event_channel, want.ch));
                    if (out_bus.channel_state !== want.st)
                        flag_error($sformatf("channel_state got %0d want %0d (ch %0d)",
                                             out_bus.channel_state, want.st, want.ch));
                    if (out_bus.active_bitmap !== want.map)
                        flag_error($sformatf("active_bitmap got %h want %h (ch %0d)",
                                             out_bus.active_bitmap, want.map, want.ch));
                end
            end
            // random backpressure bursts
            if (stall_left > 0) begin
                stall_left--;
                rdy = 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 18) - 1;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            out_bus.ready <= rdy;
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb: failure");
            $finish;
        end
    end

    // stimulus list, reset and end of run
    initial begin
        logic [MODE_BITS-1:0] modes;
        int made;
        int ch;
        int run;
        logic [COND_BITS-1:0] cnd;

        i_rst_n = 1'b0;
        in_bus.valid = 1'b0;
        in_bus.channel = '0;
        in_bus.condition = '0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = '0;
        cfg_bus.data = '0;
        out_bus.ready = 1'b0;
        raised_map = '0;
        mode_bits = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            ch_phase[c] = PH_INACTIVE;
            ch_count[c] = '0;
            ch_delay[c] = '0;
        end
        calm_now = 1'b0;

        // directed: reset config, zero delay, manual release
        push_job(JOB_STEP, 0, CND_TRIGGERED);
        push_job(JOB_STEP, 0, CND_TRIGGERED);
        push_job(JOB_STEP, 0, CND_CLEARED);
        push_job(JOB_STEP, 0, COND_HOLD);
        push_job(JOB_STEP, 0, COND_RSVD);
        push_job(JOB_STEP, 0, CND_TRIGGERED);
        push_job(JOB_STEP, 1, CND_CLEARED);
        push_job(JOB_STEP, 1, COND_HOLD);
        push_job(JOB_STEP, 3, CND_TRIGGERED);
        push_job(JOB_STEP, 3, CND_CLEARED);

        // ch0 auto release, ch1 disabled, ch2 enabled, ch3 auto; spare index ignored
        push_job(JOB_DRAIN, 0, 0);
        push_job(JOB_CFG, REG_MODES, 16'h0E54);
        push_job(JOB_CFG, REG_DELAY0 + 0, 1);
        push_job(JOB_CFG, REG_DELAY0 + 1, 0);
        push_job(JOB_CFG, REG_DELAY0 + 2, 16'hFFFF);
        push_job(JOB_CFG, REG_DELAY0 + 3, 2);
        push_job(JOB_CFG, REG_SPARE_HI, 16'hFFFF);
        push_job(JOB_STEP, 0, CND_CLEARED);
        push_job(JOB_STEP, 0, CND_TRIGGERED);
        push_job(JOB_STEP, 0, CND_CLEARED);
        push_job(JOB_STEP, 0, CND_CLEARED);
        push_job(JOB_STEP, 0, CND_CLEARED);
        push_job(JOB_STEP, 1, CND_TRIGGERED);
        push_job(JOB_STEP, 2, CND_TRIGGERED);
        push_job(JOB_STEP, 2, CND_TRIGGERED);
        push_job(JOB_STEP, 2, CND_CLEARED);
        for (int k = 0; k < 4; k++)
            push_job(JOB_STEP, 3, CND_TRIGGERED);
        push_job(JOB_STEP, 0, CND_TRIGGERED);

        // disable ch0 while pre-active and ch3 while active
        push_job(JOB_DRAIN, 0, 0);
        push_job(JOB_CFG, REG_MODES, 16'h0452);
        push_job(JOB_STEP, 0, COND_HOLD);
        push_job(JOB_STEP, 3, COND_HOLD);
        push_job(JOB_STEP, 3, COND_HOLD);

        // random phases, each with a fresh setting
        for (int p = 0; p < RAND_PHASES; p++) begin
            calm_now = (p >= RAND_PHASES - 2) || (p % 5 == 3);
            push_job(JOB_DRAIN, 0, 0);
            if (p == 0)
                modes = '0;
            else if (p == 1)
                modes = '1;
            else if (p == 4)
                modes = 12'h492;
            else
                for (int c = 0; c < CHANNELS; c++)
                    modes[MODE_CH_BITS*c +: MODE_CH_BITS] = pick_mode();
            push_job(JOB_CFG, REG_MODES, {4'($urandom_range(0, 15)), modes});
            for (int c = 0; c < CHANNELS; c++) begin
                if (p == 2)
                    push_job(JOB_CFG, REG_DELAY0 + c, 16'hFFFF);
                else if (p == 0 || $urandom_range(0, 1) == 0)
                    push_job(JOB_CFG, REG_DELAY0 + c,
                             ($urandom_range(0, 11) == 0) ? $urandom_range(0, 16'hFFFF)
                                                          : $urandom_range(0, 3));
            end
            if (p % 4 == 1)
                push_job(JOB_CFG, $urandom_range(REG_SPARE_LO, REG_SPARE_HI),
                         $urandom_range(0, 16'hFFFF));

            // runs of one condition on one channel, with noise steps mixed in
            made = 0;
            while (made < STEPS_PER_PHASE) begin
                ch  = $urandom_range(0, CHANNELS - 1);
                cnd = pick_cond();
                run = $urandom_range(1, 6);
                for (int k = 0; k < run; k++) begin
                    if ($urandom_range(0, 4) == 0) begin
                        push_job(JOB_STEP, $urandom_range(0, CHANNELS - 1),
                                 $urandom_range(0, 3));
                        made++;
                    end
                    push_job(JOB_STEP, ch, cnd);
                    made++;
                end
                if ($urandom_range(0, 39) == 0)
                    push_job(JOB_DRAIN, 0, 0);
            end
        end
        push_job(JOB_DRAIN, 0, 0);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait for the list to run dry and every result to arrive
        do
            @(negedge i_clk);
        while (scan_jobs.size() != 0 || drain_wait || in_bus.valid || cfg_bus.valid
               || pending_results.size() != 0);
        repeat (3 * SETTLE_CYCLES) @(negedge i_clk);
        if (pending_results.size() != 0)
            flag_error($sformatf("%0d results never arrived", pending_results.size()));

        $display("ran %0d scan steps and %0d register writes in %0d cycles",
                 steps_taken, reg_writes, cycles);
        $display("checked %0d results: %0d alarms raised, %0d ended, %0d mismatches",
                 results_seen, raised_seen, ended_seen, errors);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ alarm_qualify_fsm.f @@
hw/rtl/aqf_pkg.sv
hw/rtl/aqf_ifs.sv
hw/rtl/aqf_cfg_regs.sv
hw/rtl/aqf_chan_step.sv
hw/rtl/alarm_qualify_fsm.sv
hw/rtl/aqf_checker.sv
tb/alarm_qualify_fsm_tb.sv
